[src/pov_slice_buffer_driver_defines.svh]
// Assertion macros used by the slice buffer driver datapath.
`ifndef POV_SLICE_BUFFER_DRIVER_DEFINES_SVH
`define POV_SLICE_BUFFER_DRIVER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define PSBD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("slice buffer driver check failed");

// Checks that a condition implies a consequence in the same cycle.
`define PSBD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("slice buffer driver check failed");

`endif

[src/psbd_pkg.sv]
// Shared types, codes and defaults of the slice buffer driver.
`default_nettype none

package psbd_pkg;

    localparam int DEF_NUM_SLICES        = 360;
    localparam int DEF_BYTES_PER_SLICE   = 16;
    localparam int DEF_HALL_GUARD_SLICES = 180;
    localparam int DEF_TIMER_BITS        = 24;

    localparam int MODE_W    = 3;
    localparam int SI_W      = 9;
    localparam int RI_W      = 5;
    localparam int ARM_W     = 8;
    localparam int PERIOD_W  = 24;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 24'hFF_FFFF;

    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RST_CNT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HALL    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ADD_WR,
        ST_PUSH,
        ST_HALL
    } state_t;

    typedef struct packed {
        logic item_load;
        logic mem_rd_item;
        logic mem_rd_cnt;
        logic mem_wr_add;
        logic clr_step;
        logic byte_step;
        logic period_load;
        logic cnt_inc;
        logic cnt_clr;
        logic cnt_guard;
        logic timer_clr;
        logic timer_inc;
        logic first_clr;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              add_ok;
        logic              push_ok;
        logic              first_pending;
        logic              guard_ok;
        logic              clr_last;
        logic              byte_last;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

[src/psbd_ctrl.sv]
// Controller state machine of the slice buffer driver.
`default_nettype none

module psbd_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire psbd_pkg::sts_t sts,
    output psbd_pkg::cmd_t     cmd
);

    psbd_pkg::state_t state_reg;
    psbd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psbd_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psbd_pkg::ST_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = psbd_pkg::ST_IDLE;
                end
            end
            psbd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = psbd_pkg::ST_DECODE;
                end
            end
            psbd_pkg::ST_DECODE: begin
                state_next = psbd_pkg::ST_IDLE;
                unique case (sts.mode)
                    psbd_pkg::MODE_ADD: begin
                        if (sts.add_ok) begin
                            state_next = psbd_pkg::ST_ADD_WR;
                        end
                    end
                    psbd_pkg::MODE_CLEAR: begin
                        state_next = psbd_pkg::ST_CLEAR;
                    end
                    psbd_pkg::MODE_PUSH: begin
                        if (sts.push_ok) begin
                            state_next = psbd_pkg::ST_PUSH;
                        end
                    end
                    psbd_pkg::MODE_HALL: begin
                        if (!sts.first_pending && sts.guard_ok) begin
                            state_next = psbd_pkg::ST_HALL;
                        end
                    end
                    default: begin
                        state_next = psbd_pkg::ST_IDLE;
                    end
                endcase
            end
            psbd_pkg::ST_ADD_WR: begin
                state_next = psbd_pkg::ST_IDLE;
            end
            psbd_pkg::ST_PUSH: begin
                if (sts.out_free && sts.byte_last) begin
                    state_next = psbd_pkg::ST_IDLE;
                end
            end
            psbd_pkg::ST_HALL: begin
                if (sts.out_free) begin
                    state_next = psbd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            psbd_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
            end
            psbd_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.item_load = s_tvalid;
            end
            psbd_pkg::ST_DECODE: begin
                unique case (sts.mode)
                    psbd_pkg::MODE_ADD: begin
                        cmd.mem_rd_item = sts.add_ok;
                    end
                    psbd_pkg::MODE_PUSH: begin
                        cmd.mem_rd_cnt = sts.push_ok;
                    end
                    psbd_pkg::MODE_RST_CNT: begin
                        cmd.cnt_clr = 1'b1;
                    end
                    psbd_pkg::MODE_HALL: begin
                        if (sts.first_pending) begin
                            cmd.timer_clr = 1'b1;
                            cmd.first_clr = 1'b1;
                            cmd.cnt_guard = 1'b1;
                        end
                    end
                    psbd_pkg::MODE_TICK: begin
                        cmd.timer_inc = !sts.first_pending;
                    end
                    default: begin
                        cmd = '0;
                    end
                endcase
            end
            psbd_pkg::ST_ADD_WR: begin
                cmd.mem_wr_add = 1'b1;
            end
            psbd_pkg::ST_PUSH: begin
                cmd.byte_step = sts.out_free;
                cmd.cnt_inc   = sts.out_free && sts.byte_last;
            end
            psbd_pkg::ST_HALL: begin
                cmd.period_load = sts.out_free;
                cmd.timer_clr   = sts.out_free;
                cmd.cnt_clr     = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/psbd_datapath.sv]
// Datapath of the slice buffer driver: slice memory, counters, timer and output register.
`default_nettype none
`include "pov_slice_buffer_driver_defines.svh"

module psbd_datapath #(
    parameter int NUM_SLICES        = psbd_pkg::DEF_NUM_SLICES,
    parameter int BYTES_PER_SLICE   = psbd_pkg::DEF_BYTES_PER_SLICE,
    parameter int HALL_GUARD_SLICES = psbd_pkg::DEF_HALL_GUARD_SLICES,
    parameter int TIMER_BITS        = psbd_pkg::DEF_TIMER_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire psbd_pkg::cmd_t                 cmd,
    output psbd_pkg::sts_t                      sts,
    input  wire logic [psbd_pkg::MODE_W-1:0]    s_tuser,
    input  wire logic [psbd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [psbd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    localparam int ADDR_W  = $clog2(NUM_SLICES);
    localparam int BI_W    = (BYTES_PER_SLICE > 1) ? $clog2(BYTES_PER_SLICE) : 1;
    localparam int HALF    = BYTES_PER_SLICE / 2;
    localparam int UPPER   = BYTES_PER_SLICE - HALF;
    localparam int CNT_MAX = (NUM_SLICES > HALL_GUARD_SLICES) ? NUM_SLICES : HALL_GUARD_SLICES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int SI_W    = psbd_pkg::SI_W;
    localparam int RI_W    = psbd_pkg::RI_W;
    localparam int ARM_W   = psbd_pkg::ARM_W;

    typedef logic [BYTES_PER_SLICE-1:0][ARM_W-1:0] row_t;

    row_t slice_mem [NUM_SLICES];
    row_t row_reg;
    row_t add_row;

    logic [psbd_pkg::MODE_W-1:0] mode_reg;
    logic [SI_W-1:0]             si_reg;
    logic [RI_W-1:0]             ri_reg;
    logic [ARM_W-1:0]            pat_reg;

    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic                  first_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [ADDR_W-1:0]     clr_cnt_next;
    logic [BI_W-1:0]       byte_cnt_reg;
    logic [BI_W-1:0]       byte_cnt_next;
    logic [BI_W-1:0]       byte_pos;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_kind_reg;
    logic [ARM_W-1:0]              out_bits_reg;
    logic                          out_last_reg;
    logic [psbd_pkg::PERIOD_W-1:0] out_period_reg;
    logic [psbd_pkg::PERIOD_W-1:0] period_sat;
    logic [31:0]                   timer_wide;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    row_t              wr_data;
    logic              out_free;
    logic              byte_last;
    logic              clr_last;

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            mode_reg <= s_tuser;
            si_reg   <= s_tdata[SI_W-1:0];
            ri_reg   <= s_tdata[SI_W +: RI_W];
            pat_reg  <= s_tdata[SI_W+RI_W +: ARM_W];
        end
    end

    // The pattern is ORed into the addressed byte of the row just read.
    always_comb begin
        for (int b = 0; b < BYTES_PER_SLICE; b++) begin
            add_row[b] = row_reg[b] | ((32'(ri_reg) == b) ? pat_reg : '0);
        end
    end

    assign wr_addr = cmd.clr_step ? clr_cnt_reg : ADDR_W'(si_reg);
    assign wr_data = cmd.clr_step ? '0 : add_row;
    assign rd_addr = cmd.mem_rd_cnt ? ADDR_W'(cnt_reg) : ADDR_W'(si_reg);

    always_ff @(posedge aclk) begin
        if (cmd.clr_step || cmd.mem_wr_add) begin
            slice_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd_cnt || cmd.mem_rd_item) begin
            row_reg <= slice_mem[rd_addr];
        end
    end

    assign clr_last     = clr_cnt_reg == ADDR_W'(NUM_SLICES - 1);
    assign clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;

    // Bytes leave upper half first, then lower half in falling order.
    always_comb begin
        if (32'(byte_cnt_reg) < 32'(UPPER)) begin
            byte_pos = BI_W'(32'(HALF) + 32'(byte_cnt_reg));
        end else begin
            byte_pos = BI_W'(32'(BYTES_PER_SLICE - 1) - 32'(byte_cnt_reg));
        end
    end

    assign byte_last     = byte_cnt_reg == BI_W'(BYTES_PER_SLICE - 1);
    assign byte_cnt_next = byte_last ? '0 : byte_cnt_reg + 1'b1;

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_guard) begin
            cnt_next = CNT_W'(HALL_GUARD_SLICES);
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        timer_next = timer_reg;
        if (cmd.timer_clr) begin
            timer_next = '0;
        end else if (cmd.timer_inc && (timer_reg != '1)) begin
            timer_next = timer_reg + 1'b1;
        end
    end

    assign timer_wide = 32'(timer_reg);
    assign period_sat = (timer_wide > 32'(psbd_pkg::PERIOD_MAX)) ?
                        psbd_pkg::PERIOD_MAX : timer_wide[psbd_pkg::PERIOD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            timer_reg    <= '0;
            first_reg    <= 1'b1;
            clr_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            timer_reg <= timer_next;
            if (cmd.first_clr) begin
                first_reg <= 1'b0;
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_next;
            end
            if (cmd.byte_step) begin
                byte_cnt_reg <= byte_cnt_next;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.byte_step || cmd.period_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.byte_step) begin
            out_kind_reg   <= 1'b0;
            out_bits_reg   <= row_reg[byte_pos];
            out_last_reg   <= byte_last;
            out_period_reg <= '0;
        end else if (cmd.period_load) begin
            out_kind_reg   <= 1'b1;
            out_bits_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_period_reg <= period_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_period_reg, out_bits_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    assign sts.mode          = mode_reg;
    assign sts.add_ok        = (32'(si_reg) < 32'(NUM_SLICES)) &&
                               (32'(ri_reg) < 32'(BYTES_PER_SLICE));
    assign sts.push_ok       = 32'(cnt_reg) < 32'(NUM_SLICES);
    assign sts.first_pending = first_reg;
    assign sts.guard_ok      = 32'(cnt_reg) >= 32'(HALL_GUARD_SLICES);
    assign sts.clr_last      = clr_last;
    assign sts.byte_last     = byte_last;
    assign sts.out_free      = out_free;

    `PSBD_ASSERT_IMPL(a_byte_into_free_slot, aclk, aresetn, cmd.byte_step, out_free)
    `PSBD_ASSERT_IMPL(a_push_row_in_range, aclk, aresetn, cmd.mem_rd_cnt,
                      32'(cnt_reg) < 32'(NUM_SLICES))
    `PSBD_ASSERT(a_one_writer, aclk, aresetn, !(cmd.clr_step && cmd.mem_wr_add))
    `PSBD_ASSERT_IMPL(a_last_byte_advances, aclk, aresetn, cmd.byte_step && byte_last,
                      cmd.cnt_inc)

endmodule

`default_nettype wire

[src/pov_slice_buffer_driver.sv]
// An add reads the addressed row and writes it back with the pattern; a push reads the
// row at the slice counter and sends its 16 bytes, one byte per cycle from the row register
// while the receiver takes them. No new command is taken until the current one is done; a
// clear sweeps the slice memory one row a cycle. Reset is synchronous and active low; after
// it the block clears the memory row by row, all NUM_SLICES rows (360 by default), before it takes its first transfer.
`default_nettype none

module pov_slice_buffer_driver #(
    parameter int NUM_SLICES        = psbd_pkg::DEF_NUM_SLICES,
    parameter int BYTES_PER_SLICE   = psbd_pkg::DEF_BYTES_PER_SLICE,
    parameter int HALL_GUARD_SLICES = psbd_pkg::DEF_HALL_GUARD_SLICES,
    parameter int TIMER_BITS        = psbd_pkg::DEF_TIMER_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata fields from bit 0: slice_index[8:0], radial_index[13:9], pattern[21:14].
    input  wire logic [psbd_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0: mode[2:0].
    input  wire logic [psbd_pkg::MODE_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata fields from bit 0: arm_bits[7:0], period_us[31:8].
    output logic [psbd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // m_tuser fields from bit 0: kind[0].
    output logic                                m_tuser
);

    psbd_pkg::cmd_t cmd;
    psbd_pkg::sts_t sts;

    psbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psbd_datapath #(
        .NUM_SLICES        (NUM_SLICES),
        .BYTES_PER_SLICE   (BYTES_PER_SLICE),
        .HALL_GUARD_SLICES (HALL_GUARD_SLICES),
        .TIMER_BITS        (TIMER_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[test/pov_slice_buffer_driver_test.sv]
// Self-checking stream testbench for the rotating-arm slice buffer driver.
`default_nettype none

module pov_slice_buffer_driver_test;

    localparam int MODE_W    = psbd_pkg::MODE_W;
    localparam int SI_W      = psbd_pkg::SI_W;
    localparam int RI_W      = psbd_pkg::RI_W;
    localparam int ARM_W     = psbd_pkg::ARM_W;
    localparam int PERIOD_W  = psbd_pkg::PERIOD_W;
    localparam int S_TDATA_W = psbd_pkg::S_TDATA_W;
    localparam int M_TDATA_W = psbd_pkg::M_TDATA_W;

    localparam int N_SLICES    = psbd_pkg::DEF_NUM_SLICES;
    localparam int N_BYTES     = psbd_pkg::DEF_BYTES_PER_SLICE;
    localparam int GUARD       = psbd_pkg::DEF_HALL_GUARD_SLICES;
    localparam int PAST_END    = 4;
    localparam int FREE_ITEMS  = 30;
    localparam int PHASE_A_END = 120;
    localparam int PHASE_B_END = 240;
    localparam int HOLD_AT     = 800;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN       = 450;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [MODE_W-1:0]   MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0]   MODE_SPARE7 = 3'd7;
    localparam logic                KIND_ARM    = 1'b0;
    localparam logic                KIND_PERIOD = 1'b1;
    localparam logic [PERIOD_W-1:0] TIMER_TOP   = 24'hFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SI_W-1:0]   slice;
        logic [RI_W-1:0]   radial;
        logic [ARM_W-1:0]  pattern;
    } slice_cmd_t;

    typedef struct packed {
        logic                kind;
        logic [ARM_W-1:0]    arm;
        logic                last;
        logic [PERIOD_W-1:0] period;
    } column_out_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SI_W-1:0]   slice;
        logic [RI_W-1:0]   radial;
        logic [ARM_W-1:0]  pattern;
        logic              lit;
        logic [ARM_W-1:0]  lit_arm;
    } dir_row_t;

    // Rows with lit set expect every column byte to equal lit_arm.
    dir_row_t directed_rows [23] = '{
        '{psbd_pkg::MODE_PUSH,    9'd0,   5'd0,  8'h00, 1'b1, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd1,   5'd0,  8'h01, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd1,   5'd15, 8'h80, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd1,   5'd8,  8'hFF, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd1,   5'd7,  8'h5A, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd1,   5'd8,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd359, 5'd15, 8'hFF, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd360, 5'd0,  8'hFF, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd511, 5'd31, 8'hFF, 1'b0, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd1,   5'd16, 8'hFF, 1'b0, 8'h00},
        '{psbd_pkg::MODE_PUSH,    9'd511, 5'd31, 8'hFF, 1'b0, 8'h00},
        '{MODE_SPARE6,            9'd511, 5'd31, 8'hFF, 1'b0, 8'h00},
        '{MODE_SPARE7,            9'd1,   5'd1,  8'h01, 1'b0, 8'h00},
        '{psbd_pkg::MODE_TICK,    9'd0,   5'd0,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_CLEAR,   9'd0,   5'd0,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_RST_CNT, 9'd0,   5'd0,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_PUSH,    9'd0,   5'd0,  8'h00, 1'b1, 8'h00},
        '{psbd_pkg::MODE_HALL,    9'd0,   5'd0,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_TICK,    9'd0,   5'd0,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_TICK,    9'd0,   5'd0,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_TICK,    9'd0,   5'd0,  8'h00, 1'b0, 8'h00},
        '{psbd_pkg::MODE_PUSH,    9'd0,   5'd0,  8'h00, 1'b1, 8'h00},
        '{psbd_pkg::MODE_ADD,     9'd181, 5'd3,  8'hC3, 1'b0, 8'h00}
    };

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    logic [ARM_W-1:0]    column_mem [0:N_SLICES*N_BYTES-1];
    logic [SI_W-1:0]     slice_ptr;
    logic                first_edge_wait;
    logic [PERIOD_W-1:0] rev_timer;
    column_out_t         step_out [0:N_BYTES-1];
    column_out_t         awaited_columns [$];

    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int          items_sent        = 0;
    int          outputs_seen      = 0;
    int          mismatch_count    = 0;
    int unsigned cycle_count       = 0;
    column_out_t got_col;
    column_out_t want_col;

    pov_slice_buffer_driver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void reset_model();
        foreach (column_mem[i]) column_mem[i] = '0;
        slice_ptr       = '0;
        first_edge_wait = 1'b1;
        rev_timer       = '0;
    endfunction

    // Updates the model state and fills step_out; returns the number of results.
    function automatic int step_model(input slice_cmd_t c);
        int n;
        int base;
        int pos;
        int i;
        n = 0;
        case (c.mode)
            psbd_pkg::MODE_ADD: begin
                if (c.slice < N_SLICES && c.radial < N_BYTES)
                    column_mem[c.slice*N_BYTES + c.radial] |= c.pattern;
            end
            psbd_pkg::MODE_CLEAR: begin
                foreach (column_mem[j]) column_mem[j] = '0;
            end
            psbd_pkg::MODE_PUSH: begin
                if (slice_ptr < N_SLICES) begin
                    base = slice_ptr * N_BYTES;
                    for (i = 0; i < N_BYTES; i++) begin
                        pos = (i < N_BYTES - N_BYTES/2) ? N_BYTES/2 + i : N_BYTES - 1 - i;
                        step_out[n] = '{KIND_ARM, column_mem[base+pos], i == N_BYTES-1, '0};
                        n++;
                    end
                    slice_ptr++;
                end
            end
            psbd_pkg::MODE_RST_CNT: slice_ptr = '0;
            psbd_pkg::MODE_HALL: begin
                if (first_edge_wait) begin
                    rev_timer       = '0;
                    first_edge_wait = 1'b0;
                    slice_ptr       = SI_W'(GUARD);
                end else if (slice_ptr >= GUARD) begin
                    step_out[0] = '{KIND_PERIOD, 8'h00, 1'b0,
                                    rev_timer > psbd_pkg::PERIOD_MAX ?
                                    psbd_pkg::PERIOD_MAX : rev_timer};
                    n           = 1;
                    rev_timer   = '0;
                    slice_ptr   = '0;
                end
            end
            psbd_pkg::MODE_TICK: begin
                if (!first_edge_wait && rev_timer < TIMER_TOP) rev_timer++;
            end
            default: ;
        endcase
        return n;
    endfunction

    task automatic send_command(input slice_cmd_t c, input logic lit,
                                input logic [ARM_W-1:0] lit_arm);
        int n;
        int k;
        column_out_t col;
        if (items_sent < PHASE_A_END) begin
            sender_idle_pct   = 10;
            receiver_idle_pct = 61;
        end else if (items_sent < PHASE_B_END) begin
            sender_idle_pct   = 61;
            receiver_idle_pct = 10;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.mode;
        s_tdata  <= {2'b00, c.pattern, c.radial, c.slice};
        do @(posedge aclk); while (!s_tready);
        n = step_model(c);
        for (k = 0; k < n; k++) begin
            col = step_out[k];
            if (lit) col.arm = lit_arm;
            awaited_columns.push_back(col);
        end
        items_sent++;
    endtask

    task automatic note_mismatch(input logic unexpected, input column_out_t want,
                                 input column_out_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (unexpected)
                $display("Unexpected transfer: kind=%0d arm=%02h last=%0d period=%06h",
                         got.kind, got.arm, got.last, got.period);
            else
                $display("Mismatch: expected kind=%0d arm=%02h last=%0d period=%06h, %s",
                         want.kind, want.arm, want.last, want.period,
                         $sformatf("got kind=%0d arm=%02h last=%0d period=%06h",
                                   got.kind, got.arm, got.last, got.period));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            outputs_seen <= outputs_seen + 1;
            got_col = '{m_tuser, m_tdata[7:0], m_tlast, m_tdata[31:8]};
            if (awaited_columns.size() == 0) begin
                note_mismatch(1'b1, '0, got_col);
            end else begin
                want_col = awaited_columns.pop_front();
                if (got_col.kind !== want_col.kind || got_col.arm !== want_col.arm ||
                    got_col.last !== want_col.last || got_col.period !== want_col.period)
                    note_mismatch(1'b0, want_col, got_col);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pov_slice_buffer_driver_test NOT OK");
            $finish;
        end
    end

    // The receiver stalls once for a long stretch so that the block backs up.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && outputs_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    initial begin
        slice_cmd_t cmd;
        int pick;
        int r;
        reset_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r_i]) begin
            cmd = '{directed_rows[r_i].mode, directed_rows[r_i].slice,
                    directed_rows[r_i].radial, directed_rows[r_i].pattern};
            send_command(cmd, directed_rows[r_i].lit, directed_rows[r_i].lit_arm);
        end

        // Run the slice counter past the end of the frame with pattern writes ahead of it.
        while (slice_ptr < N_SLICES) begin
            pick = $urandom_range(99);
            cmd  = '{psbd_pkg::MODE_PUSH, SI_W'($urandom_range(511)),
                     RI_W'($urandom_range(31)), ARM_W'($urandom_range(255))};
            if (pick < 15) begin
                cmd.mode   = psbd_pkg::MODE_ADD;
                cmd.slice  = slice_ptr + SI_W'($urandom_range(2));
                cmd.radial = RI_W'($urandom_range(N_BYTES-1));
            end else if (pick < 20) begin
                cmd.mode = psbd_pkg::MODE_TICK;
            end
            send_command(cmd, 1'b0, 8'h00);
        end
        for (r = 0; r < PAST_END; r++) begin
            cmd = '{psbd_pkg::MODE_PUSH, SI_W'($urandom_range(511)),
                    RI_W'($urandom_range(31)), ARM_W'($urandom_range(255))};
            send_command(cmd, 1'b0, 8'h00);
        end
        cmd = '{psbd_pkg::MODE_HALL, SI_W'($urandom_range(511)), RI_W'($urandom_range(31)),
                ARM_W'($urandom_range(255))};
        send_command(cmd, 1'b0, 8'h00);

        for (r = 0; r < FREE_ITEMS; r++) begin
            pick = $urandom_range(99);
            cmd  = '{psbd_pkg::MODE_TICK, SI_W'($urandom_range(511)),
                     RI_W'($urandom_range(31)), ARM_W'($urandom_range(255))};
            if (pick < 35) begin
                cmd.mode = psbd_pkg::MODE_ADD;
                if ($urandom_range(99) < 60) begin
                    cmd.slice  = slice_ptr + SI_W'($urandom_range(3));
                    cmd.radial = RI_W'($urandom_range(N_BYTES-1));
                end
            end else if (pick < 60) begin
                cmd.mode = psbd_pkg::MODE_PUSH;
            end else if (pick < 83 && pick >= 75) begin
                cmd.mode = psbd_pkg::MODE_HALL;
            end else if (pick < 88 && pick >= 83) begin
                cmd.mode = psbd_pkg::MODE_RST_CNT;
            end else if (pick < 91 && pick >= 88) begin
                cmd.mode = psbd_pkg::MODE_CLEAR;
            end else if (pick < 95 && pick >= 91) begin
                cmd.mode = $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
            end
            send_command(cmd, 1'b0, 8'h00);
        end

        s_tvalid <= 1'b0;
        while (awaited_columns.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatch_count == 0 && awaited_columns.size() == 0) begin
            $display("pov_slice_buffer_driver_test OK");
        end else begin
            $display("pov_slice_buffer_driver_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
